// File: sv/b64dkx_pkg.sv
// Package: shared types, constants and the character map for the base64 key-XOR decoder.
`timescale 1ns / 1ps
`default_nettype none

package b64dkx_pkg;

    localparam int KEY_BYTES    = 32;
    localparam int KEY_IDX_W    = $clog2(KEY_BYTES);
    localparam int KEY_LEN_W    = 6;
    localparam int KEY_BITS     = KEY_BYTES * 8;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 6;
    localparam int REG_IDX_W    = 3;

    // Register indexes, byte address is 8 times the index.
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD0  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD1  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD2  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD3  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 3'd4;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd1;

    localparam logic [7:0] PAD_CODE = 8'h3D;

    // Group positions.
    localparam logic [1:0] GRP_FIRST  = 2'd0;
    localparam logic [1:0] GRP_SECOND = 2'd1;
    localparam logic [1:0] GRP_THIRD  = 2'd2;
    localparam logic [1:0] GRP_FOURTH = 2'd3;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key_bits;
        logic [KEY_LEN_W-1:0] key_length;
    } t_key_cfg;

    // Map an ASCII code to its base64 sextet; anything else maps to zero.
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30 + 8'd52;
        end else if (c == 8'h2B) begin
            v = 8'd62;
        end else if (c == 8'h2F) begin
            v = 8'd63;
        end
        return v[5:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/b64dkx_regs.sv
// Configuration register file: key words and key length behind an APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module b64dkx_regs
    import b64dkx_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_key_cfg                   o_key_cfg
);

    logic [CFG_DATA_W-1:0] r_key_word [4];
    logic [KEY_LEN_W-1:0]  r_key_length;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_word[0] <= '0;
            r_key_word[1] <= '0;
            r_key_word[2] <= '0;
            r_key_word[3] <= '0;
            r_key_length  <= KEY_LEN_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_KEY_WORD0:  r_key_word[0] <= pwdata;
                REG_KEY_WORD1:  r_key_word[1] <= pwdata;
                REG_KEY_WORD2:  r_key_word[2] <= pwdata;
                REG_KEY_WORD3:  r_key_word[3] <= pwdata;
                REG_KEY_LENGTH: r_key_length  <= pwdata[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KEY_WORD0:  prdata = r_key_word[0];
            REG_KEY_WORD1:  prdata = r_key_word[1];
            REG_KEY_WORD2:  prdata = r_key_word[2];
            REG_KEY_WORD3:  prdata = r_key_word[3];
            REG_KEY_LENGTH: prdata = {{(CFG_DATA_W-KEY_LEN_W){1'b0}}, r_key_length};
            default:        prdata = '0;
        endcase
    end

    assign o_key_cfg.key_bits   = {r_key_word[3], r_key_word[2], r_key_word[1], r_key_word[0]};
    assign o_key_cfg.key_length = r_key_length;

endmodule

`default_nettype wire

// File: sv/b64dkx_core.sv
// Decode datapath: group, carry and key position state, byte assembly and key XOR.
`timescale 1ns / 1ps
`default_nettype none

module b64dkx_core
    import b64dkx_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic [7:0] i_symbol,
    input  wire logic       i_message_start,
    input  t_key_cfg        i_key_cfg,
    output logic            o_emit,
    output logic      [7:0] o_data_byte
);

    logic [1:0]           r_group_pos,  n_group_pos;
    logic [5:0]           r_carry,      n_carry;
    logic [KEY_IDX_W-1:0] r_key_pos,    n_key_pos;

    logic [1:0]           pos;
    logic [5:0]           carry;
    logic [KEY_IDX_W-1:0] kpos;
    logic [5:0]           sext;
    logic                 pad;
    logic [7:0]           plain;
    logic [KEY_LEN_W-1:0] len;
    logic [KEY_LEN_W-1:0] idx;
    logic [KEY_LEN_W-1:0] idx_next;
    logic [7:0]           key_byte;

    // Message start clears position state ahead of this symbol.
    assign pos   = i_message_start ? GRP_FIRST : r_group_pos;
    assign carry = i_message_start ? 6'd0 : r_carry;
    assign kpos  = i_message_start ? '0 : r_key_pos;

    assign sext = sextet_of(i_symbol);
    assign pad  = (i_symbol == PAD_CODE);

    always_comb begin
        case (pos)
            GRP_SECOND: begin
                plain  = {carry, sext[5:4]};
                o_emit = 1'b1;
            end
            GRP_THIRD: begin
                plain  = {carry[3:0], sext[5:2]};
                o_emit = !pad;
            end
            GRP_FOURTH: begin
                plain  = {carry[1:0], sext};
                o_emit = !pad;
            end
            default: begin
                plain  = 8'd0;
                o_emit = 1'b0;
            end
        endcase
    end

    // Clamp key length into 1..KEY_BYTES.
    always_comb begin
        len = i_key_cfg.key_length;
        if (len == '0) begin
            len = KEY_LEN_W'(1);
        end else if (len > KEY_LEN_W'(KEY_BYTES)) begin
            len = KEY_LEN_W'(KEY_BYTES);
        end
    end

    assign idx      = ({1'b0, kpos} >= len) ? '0 : {1'b0, kpos};
    assign idx_next = (idx + KEY_LEN_W'(1) >= len) ? '0 : idx + KEY_LEN_W'(1);
    assign key_byte = i_key_cfg.key_bits[idx[KEY_IDX_W-1:0]*8 +: 8];

    assign o_data_byte = plain ^ key_byte;

    assign n_group_pos = pos + 2'd1;
    assign n_carry     = sext;
    assign n_key_pos   = o_emit ? idx_next[KEY_IDX_W-1:0] : kpos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_pos <= GRP_FIRST;
            r_carry     <= '0;
            r_key_pos   <= '0;
        end else if (i_advance) begin
            r_group_pos <= n_group_pos;
            r_carry     <= n_carry;
            r_key_pos   <= n_key_pos;
        end
    end

endmodule

`default_nettype wire

// File: sv/base64_decode_key_xor.sv
// Top level: base64 character decoder with repeating-key XOR on each decoded byte.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------
//  in       | sink      | i_in_valid / o_in_stall | i_symbol, i_message_start
//  out      | source    | o_out_valid/ i_out_stall| o_data_byte
//  cfg      | APB slave | psel, penable, pready   | paddr, pwdata, prdata
//
//  One item per cycle sustained while the output is not stalled. A symbol is
//  held in the input register, is decoded against the group/key state, and
//  its byte (if any) is then registered in the output register.
//  Items that make no byte (1st place of a group, padding) still take a slot.
//  Reset is synchronous, active low, and clears state, key words, and sets
//  key length to 1. A stalled output holds its byte; the input stalls only
//  when both registers are full and the output is stalled.
//
module base64_decode_key_xor
    import b64dkx_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input items
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_symbol,
    input  wire logic                  i_message_start,
    // result items
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [7:0]            o_data_byte,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_key_cfg   key_cfg;

    // input register
    logic       r_in_valid;
    logic [7:0] r_symbol;
    logic       r_start;

    // result register
    logic       r_out_valid;
    logic [7:0] r_data_byte;

    logic       out_free;
    logic       advance;
    logic       in_accept;
    logic       emit;
    logic [7:0] byte_val;

    // The result register can take a new byte when empty or being drained.
    assign out_free   = !r_out_valid || !i_out_stall;
    // Move the held symbol through the decoder; state updates on this.
    assign advance    = r_in_valid && out_free;
    // Stall the input only while the held symbol cannot move on.
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    b64dkx_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_key_cfg (key_cfg)
    );

    b64dkx_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_symbol        (r_symbol),
        .i_message_start (r_start),
        .i_key_cfg       (key_cfg),
        .o_emit          (emit),
        .o_data_byte     (byte_val)
    );

    // Input register: load on accept, empty when the item moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_symbol <= i_symbol;
            r_start  <= i_message_start;
        end
    end

    // Result register: refill on advance (only when a byte is made), drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_data_byte <= byte_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_data_byte;

endmodule

`default_nettype wire

// File: sv/b64dkx_chk.sv
// Port-level checker for the base64 key-XOR decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module b64dkx_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       i_message_start,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_data_byte
);

    // No result right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data_byte))
        else $error("stalled result changed");

    // Input stalls only when the output side is full and blocked.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with free output");

    // A symbol that opens a message is the first of a group and makes no byte.
    a_start_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_in_valid && !o_in_stall && i_message_start) && $past(i_rst_n)
        && (!o_out_valid || !i_out_stall) |=> !o_out_valid)
        else $error("message start produced a byte");

endmodule

bind base64_decode_key_xor b64dkx_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_message_start (i_message_start),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_data_byte     (o_data_byte)
);

`default_nettype wire
